// ----- rtl/sdce_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdce_pkg
// Types, codes and lookup functions shared by the display command encoder.
// ---------------------------------------------------------------------------
package sdce_pkg;

  typedef enum logic [1:0] {
    REQ_DIGIT        = 2'd0,
    REQ_DIGIT_BRIGHT = 2'd1,
    REQ_LED          = 2'd2,
    REQ_LED_BRIGHT   = 2'd3
  } req_t;

  localparam logic       BUS_DIGIT = 1'b0;
  localparam logic       BUS_LED   = 1'b1;
  localparam logic [7:0] CTRL_ADDR = 8'h48;
  localparam logic [7:0] POINT_BIT = 8'h80;
  localparam logic [3:0] MAX_LEVEL = 4'd8;
  localparam logic [2:0] LAST_IDX  = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] position;
    logic [4:0] symbol_value;
    logic       point;
    logic [3:0] brightness;
  } item_t;

  typedef struct packed {
    logic       bus_select;
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } res_t;

  function automatic logic [7:0] seg_pattern(input logic [4:0] sym);
    logic [7:0] pat;
    case (sym)
      5'd0:    pat = 8'h3f;
      5'd1:    pat = 8'h06;
      5'd2:    pat = 8'h5b;
      5'd3:    pat = 8'h4f;
      5'd4:    pat = 8'h66;
      5'd5:    pat = 8'h6d;
      5'd6:    pat = 8'h7d;
      5'd7:    pat = 8'h07;
      5'd8:    pat = 8'h7f;
      5'd9:    pat = 8'h6f;
      5'd10:   pat = 8'h77;
      5'd11:   pat = 8'h7c;
      5'd12:   pat = 8'h39;
      5'd13:   pat = 8'h5e;
      5'd14:   pat = 8'h79;
      5'd15:   pat = 8'h71;
      5'd16:   pat = 8'h40;
      5'd17:   pat = 8'h09;
      5'd18:   pat = 8'h00;
      5'd19:   pat = 8'h63;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [7:0] slot_addr(input logic [1:0] slot);
    logic [7:0] addr;
    case (slot)
      2'd0:    addr = 8'h68;
      2'd1:    addr = 8'h6A;
      2'd2:    addr = 8'h6C;
      2'd3:    addr = 8'h6E;
      default: addr = 8'h68;
    endcase
    return addr;
  endfunction

endpackage

// ----- rtl/sdce_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdce_if
// Valid/ready channels for request words and bus byte words.
// ---------------------------------------------------------------------------
interface sdce_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [4:0] position;
  logic [4:0] symbol_value;
  logic       point;
  logic [3:0] brightness;

  modport source (output valid, req_type, position, symbol_value, point, brightness,
                  input ready);
  modport sink   (input valid, req_type, position, symbol_value, point, brightness,
                  output ready);
endinterface

interface sdce_res_if;
  logic       valid;
  logic       ready;
  logic       bus_select;
  logic [7:0] bus_byte;
  logic       start_before;
  logic       stop_after;
  logic       last;

  modport source (output valid, bus_select, bus_byte, start_before, stop_after, last,
                  input ready);
  modport sink   (input valid, bus_select, bus_byte, start_before, stop_after, last,
                  output ready);
endinterface

// ----- rtl/sdce_byte_gen.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sdce_byte_gen
// Builds one bus byte word of a held request from its byte index.
// ---------------------------------------------------------------------------
module sdce_byte_gen #(
  parameter int LED_COUNT = 23
) (
  input  sdce_pkg::item_t        item,
  input  logic [2:0]             idx,
  input  logic [LED_COUNT-1:0]   led_map,
  output sdce_pkg::res_t         res
);
  import sdce_pkg::*;

  logic [23:0] map_ext;
  logic [7:0]  digit_byte;
  logic [7:0]  ctrl_byte;
  logic [7:0]  map_byte;
  logic        over_level;

  assign map_ext = 24'(led_map);
  assign over_level = item.brightness > MAX_LEVEL;

  always_comb begin
    digit_byte = seg_pattern(item.symbol_value);
    if (item.point) begin
      digit_byte = digit_byte | POINT_BIT;
    end
  end

  always_comb begin
    if (item.brightness == 4'd0) begin
      ctrl_byte = 8'h00;
    end else if (item.brightness == MAX_LEVEL) begin
      ctrl_byte = 8'h01;
    end else begin
      ctrl_byte = {item.brightness, 4'h1};
    end
  end

  always_comb begin
    case (idx[2:1])
      2'd0:    map_byte = map_ext[7:0];
      2'd1:    map_byte = map_ext[15:8];
      2'd2:    map_byte = map_ext[23:16];
      default: map_byte = 8'h00;
    endcase
  end

  always_comb begin
    res = '0;
    case (item.req_type)
      REQ_DIGIT: begin
        res.bus_select   = BUS_DIGIT;
        res.bus_byte     = idx[0] ? digit_byte : slot_addr(2'(item.position - 5'd1));
        res.start_before = !idx[0];
        res.stop_after   = idx[0];
        res.last         = idx[0];
      end
      REQ_DIGIT_BRIGHT, REQ_LED_BRIGHT: begin
        res.bus_select   = (item.req_type == REQ_LED_BRIGHT) ? BUS_LED : BUS_DIGIT;
        res.bus_byte     = idx[0] ? ctrl_byte : CTRL_ADDR;
        res.start_before = !idx[0];
        res.stop_after   = idx[0] || over_level;
        res.last         = idx[0] || over_level;
      end
      REQ_LED: begin
        res.bus_select   = BUS_LED;
        res.bus_byte     = idx[0] ? map_byte : slot_addr(idx[2:1]);
        res.start_before = !idx[0];
        res.stop_after   = idx[0];
        res.last         = idx == LAST_IDX;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- rtl/segment_display_command_encoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_display_command_encoder
// Turns display requests into two-wire bus byte words for two controllers.
// ---------------------------------------------------------------------------
// Each accepted request is held in an item register and its bus bytes leave
// one per cycle through a registered output while the sink takes them: a
// digit write or brightness request gives two byte words (one for an
// out-of-range level), an LED write gives six, and a digit write to a
// position outside 1..4 gives none. The next request is taken in the same
// cycle that the previous one's last byte enters the output register. The
// LED map updates on accept of an LED write to a position below LED_COUNT.
module segment_display_command_encoder #(
  parameter int LED_COUNT = 23
) (
  input  logic               clk,
  input  logic               rst_n,
  sdce_req_if.sink           in_ch,
  sdce_res_if.source         out_ch
);
  import sdce_pkg::*;

  logic                 hold_vld_r, hold_vld_nxt;
  item_t                item_r, item_nxt;
  logic [2:0]           idx_r, idx_nxt;
  logic [LED_COUNT-1:0] led_map_r, led_map_nxt;
  logic                 out_vld_r, out_vld_nxt;
  res_t                 out_r, out_nxt;

  item_t                in_item;
  res_t                 res;
  logic                 emit;
  logic                 in_acc;
  logic                 drop;
  logic                 load;
  logic [LED_COUNT-1:0] led_bit;

  assign in_item.req_type     = in_ch.req_type;
  assign in_item.position     = in_ch.position;
  assign in_item.symbol_value = in_ch.symbol_value;
  assign in_item.point        = in_ch.point;
  assign in_item.brightness   = in_ch.brightness;

  sdce_byte_gen #(.LED_COUNT(LED_COUNT)) u_byte_gen (
    .item    (item_r),
    .idx     (idx_r),
    .led_map (led_map_r),
    .res     (res)
  );

  assign emit        = hold_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !hold_vld_r || (emit && res.last);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign drop        = (in_ch.req_type == REQ_DIGIT) &&
                       ((in_ch.position < 5'd1) || (in_ch.position > 5'd4));
  assign load        = in_acc && !drop;
  assign led_bit     = LED_COUNT'(1) << in_ch.position;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    item_nxt     = item_r;
    idx_nxt      = idx_r;
    led_map_nxt  = led_map_r;
    if (emit) begin
      idx_nxt = idx_r + 3'd1;
      if (res.last) begin
        hold_vld_nxt = 1'b0;
      end
    end
    if (load) begin
      hold_vld_nxt = 1'b1;
      item_nxt     = in_item;
      idx_nxt      = 3'd0;
      if ((in_ch.req_type == REQ_LED) && (32'(in_ch.position) < LED_COUNT)) begin
        led_map_nxt = (in_ch.symbol_value != 5'd0) ? (led_map_r | led_bit)
                                                   : (led_map_r & ~led_bit);
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      idx_r      <= 3'd0;
      led_map_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      idx_r      <= idx_nxt;
      led_map_r  <= led_map_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.bus_select   = out_r.bus_select;
  assign out_ch.bus_byte     = out_r.bus_byte;
  assign out_ch.start_before = out_r.start_before;
  assign out_ch.stop_after   = out_r.stop_after;
  assign out_ch.last         = out_r.last;

`ifndef SYNTH
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_vld_r |-> in_ch.ready)
    else $error("request channel stalled with no held word");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !res.last) |=> hold_vld_r)
    else $error("held request dropped before its last byte");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_vld_r |-> (idx_r <= LAST_IDX))
    else $error("byte index ran past the last byte");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_vld_r)
    else $error("emitted byte not registered at the output");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment display command encoder. A table of
// directed requests covers the field extremes, every request type and the
// corner cases. Random requests follow under varying source idle and sink
// stall rates. Every bus byte word is checked in order against expected
// words from the table or a local encoder model with its own LED map copy.
// ---------------------------------------------------------------------------
module tb_top;
  import sdce_pkg::*;

  localparam int LED_COUNT       = 23;
  localparam int GLYPH_COUNT     = 20;
  localparam int RANDOM_REQUESTS = 410;
  localparam int SINK_HOLD       = 60;
  localparam int QUIET_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 16;

  localparam logic [7:0] GLYPHS [GLYPH_COUNT] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71,
    8'h40, 8'h09, 8'h00, 8'h63
  };

  typedef struct packed {
    item_t      word;
    logic       typed;
    logic [1:0] n_typed;
    res_t       first;
    res_t       second;
  } probe_t;

  localparam probe_t DIRECTED [23] = '{
    '{'{REQ_DIGIT, 5'd1, 5'd0, 1'b0, 4'd0}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h68, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h3f, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT, 5'd4, 5'd19, 1'b1, 4'd15}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h6E, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'he3, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT, 5'd2, 5'd20, 1'b0, 4'd9}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h6A, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h00, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT, 5'd3, 5'd31, 1'b1, 4'd0}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h6C, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h80, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT, 5'd0, 5'd8, 1'b1, 4'd3}, 1'b1, 2'd0, '0, '0},
    '{'{REQ_DIGIT, 5'd5, 5'd1, 1'b0, 4'd1}, 1'b1, 2'd0, '0, '0},
    '{'{REQ_DIGIT, 5'd31, 5'd31, 1'b1, 4'd15}, 1'b1, 2'd0, '0, '0},
    '{'{REQ_DIGIT_BRIGHT, 5'd31, 5'd31, 1'b1, 4'd0}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h48, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h00, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT_BRIGHT, 5'd0, 5'd0, 1'b0, 4'd1}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h48, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h11, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT_BRIGHT, 5'd2, 5'd5, 1'b0, 4'd7}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h48, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h71, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT_BRIGHT, 5'd1, 5'd2, 1'b1, 4'd8}, 1'b1, 2'd2,
      '{BUS_DIGIT, 8'h48, 1'b1, 1'b0, 1'b0}, '{BUS_DIGIT, 8'h01, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_DIGIT_BRIGHT, 5'd4, 5'd3, 1'b0, 4'd9}, 1'b1, 2'd1,
      '{BUS_DIGIT, 8'h48, 1'b1, 1'b1, 1'b1}, '0},
    '{'{REQ_DIGIT_BRIGHT, 5'd16, 5'd16, 1'b1, 4'd15}, 1'b1, 2'd1,
      '{BUS_DIGIT, 8'h48, 1'b1, 1'b1, 1'b1}, '0},
    '{'{REQ_LED_BRIGHT, 5'd3, 5'd1, 1'b0, 4'd2}, 1'b1, 2'd2,
      '{BUS_LED, 8'h48, 1'b1, 1'b0, 1'b0}, '{BUS_LED, 8'h21, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_LED_BRIGHT, 5'd31, 5'd0, 1'b1, 4'd8}, 1'b1, 2'd2,
      '{BUS_LED, 8'h48, 1'b1, 1'b0, 1'b0}, '{BUS_LED, 8'h01, 1'b0, 1'b1, 1'b1}},
    '{'{REQ_LED_BRIGHT, 5'd0, 5'd31, 1'b0, 4'd15}, 1'b1, 2'd1,
      '{BUS_LED, 8'h48, 1'b1, 1'b1, 1'b1}, '0},
    '{'{REQ_LED, 5'd0, 5'd1, 1'b0, 4'd0}, 1'b0, 2'd0, '0, '0},
    '{'{REQ_LED, 5'd22, 5'd31, 1'b1, 4'd15}, 1'b0, 2'd0, '0, '0},
    '{'{REQ_LED, 5'd23, 5'd1, 1'b0, 4'd8}, 1'b0, 2'd0, '0, '0},
    '{'{REQ_LED, 5'd31, 5'd0, 1'b1, 4'd9}, 1'b0, 2'd0, '0, '0},
    '{'{REQ_LED, 5'd15, 5'd16, 1'b0, 4'd4}, 1'b0, 2'd0, '0, '0},
    '{'{REQ_LED, 5'd0, 5'd0, 1'b1, 4'd2}, 1'b0, 2'd0, '0, '0},
    '{'{REQ_LED, 5'd8, 5'd2, 1'b0, 4'd6}, 1'b0, 2'd0, '0, '0}
  };

  logic clk;
  logic rst_n;

  sdce_req_if req_ch ();
  sdce_res_if res_ch ();

  segment_display_command_encoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  logic [LED_COUNT-1:0] led_state;
  res_t                 bus_words_due [$];
  int                   fault_count;
  int                   quiet_cycles;
  int                   src_idle_pct;
  int                   sink_stall_pct;
  int                   holds_asked;
  int                   holds_taken;
  int                   hold_left;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic void due(input logic bus, input logic [7:0] data,
                              input logic st, input logic sp, input logic lst);
    res_t r;
    r.bus_select   = bus;
    r.bus_byte     = data;
    r.start_before = st;
    r.stop_after   = sp;
    r.last         = lst;
    bus_words_due.push_back(r);
  endfunction

  function automatic void due_brightness(input logic bus, input logic [3:0] level);
    logic [7:0] ctrl;
    if (level > MAX_LEVEL) begin
      due(bus, CTRL_ADDR, 1'b1, 1'b1, 1'b1);
    end else begin
      if (level == 4'd0) ctrl = 8'h00;
      else if (level == MAX_LEVEL) ctrl = 8'h01;
      else ctrl = {level, 4'h1};
      due(bus, CTRL_ADDR, 1'b1, 1'b0, 1'b0);
      due(bus, ctrl, 1'b0, 1'b1, 1'b1);
    end
  endfunction

  function automatic void encode_request(input item_t w);
    logic [7:0]  pattern;
    logic [7:0]  addr;
    logic [23:0] map_wide;
    case (w.req_type)
      REQ_DIGIT: begin
        if (w.position >= 5'd1 && w.position <= 5'd4) begin
          addr    = 8'h68 + 8'((w.position - 5'd1) << 1);
          pattern = (w.symbol_value < GLYPH_COUNT) ? GLYPHS[w.symbol_value] : 8'h00;
          if (w.point) pattern = pattern | POINT_BIT;
          due(BUS_DIGIT, addr, 1'b1, 1'b0, 1'b0);
          due(BUS_DIGIT, pattern, 1'b0, 1'b1, 1'b1);
        end
      end
      REQ_DIGIT_BRIGHT: due_brightness(BUS_DIGIT, w.brightness);
      REQ_LED_BRIGHT:   due_brightness(BUS_LED, w.brightness);
      default: begin
        if (w.position < LED_COUNT) led_state[w.position] = (w.symbol_value != 5'd0);
        map_wide = 24'(led_state);
        due(BUS_LED, 8'h68, 1'b1, 1'b0, 1'b0);
        due(BUS_LED, map_wide[7:0], 1'b0, 1'b1, 1'b0);
        due(BUS_LED, 8'h6A, 1'b1, 1'b0, 1'b0);
        due(BUS_LED, map_wide[15:8], 1'b0, 1'b1, 1'b0);
        due(BUS_LED, 8'h6C, 1'b1, 1'b0, 1'b0);
        due(BUS_LED, map_wide[23:16], 1'b0, 1'b1, 1'b1);
      end
    endcase
  endfunction

  function automatic item_t random_request();
    item_t w;
    w.req_type     = 2'($urandom_range(0, 3));
    w.position     = 5'($urandom_range(0, 31));
    w.symbol_value = 5'($urandom_range(0, 31));
    w.point        = 1'($urandom_range(0, 1));
    w.brightness   = 4'($urandom_range(0, 15));
    if (w.req_type == REQ_DIGIT) begin
      if ($urandom_range(0, 9) != 0) w.position = 5'($urandom_range(1, 4));
      if ($urandom_range(0, 3) != 0) w.symbol_value = 5'($urandom_range(0, GLYPH_COUNT - 1));
    end else if (w.req_type == REQ_LED) begin
      if ($urandom_range(0, 7) != 0) w.position = 5'($urandom_range(0, LED_COUNT - 1));
      if ($urandom_range(0, 1) == 0) w.symbol_value = 5'd0;
    end else if ($urandom_range(0, 2) != 0) begin
      w.brightness = 4'($urandom_range(0, 8));
    end
    return w;
  endfunction

  task automatic offer(input probe_t row);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= row.word.req_type;
    req_ch.position     <= row.word.position;
    req_ch.symbol_value <= row.word.symbol_value;
    req_ch.point        <= row.word.point;
    req_ch.brightness   <= row.word.brightness;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (row.typed) begin
      if (row.n_typed > 2'd0) bus_words_due.push_back(row.first);
      if (row.n_typed > 2'd1) bus_words_due.push_back(row.second);
    end else begin
      encode_request(row.word);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      hold_left    = 0;
      holds_taken  = 0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    = hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      res_ch.ready <= 1'b0;
      holds_taken  = holds_taken + 1;
      hold_left    = SINK_HOLD;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (res_ch.valid && res_ch.ready) begin
        got.bus_select   = res_ch.bus_select;
        got.bus_byte     = res_ch.bus_byte;
        got.start_before = res_ch.start_before;
        got.stop_after   = res_ch.stop_after;
        got.last         = res_ch.last;
        if (bus_words_due.size() == 0) begin
          $error("unexpected word: bus_byte %h", got.bus_byte);
          fault_count = fault_count + 1;
        end else begin
          want = bus_words_due.pop_front();
          if (got.bus_select !== want.bus_select) begin
            $error("bus_select: expected %0d, got %0d", want.bus_select, got.bus_select);
            fault_count = fault_count + 1;
          end
          if (got.bus_byte !== want.bus_byte) begin
            $error("bus_byte: expected %h, got %h", want.bus_byte, got.bus_byte);
            fault_count = fault_count + 1;
          end
          if (got.start_before !== want.start_before) begin
            $error("start_before: expected %0d, got %0d", want.start_before,
                   got.start_before);
            fault_count = fault_count + 1;
          end
          if (got.stop_after !== want.stop_after) begin
            $error("stop_after: expected %0d, got %0d", want.stop_after, got.stop_after);
            fault_count = fault_count + 1;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fault_count = fault_count + 1;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    probe_t row;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_DIGIT;
    req_ch.position     <= 5'd0;
    req_ch.symbol_value <= 5'd0;
    req_ch.point        <= 1'b0;
    req_ch.brightness   <= 4'd0;
    led_state      = '0;
    fault_count    = 0;
    quiet_cycles   = 0;
    holds_asked    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) offer(DIRECTED[i]);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      case (i * 4 / RANDOM_REQUESTS)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 13; sink_stall_pct = 13; end
      endcase
      // park the sink and keep offering so the encoder backs up
      if (i == 0) holds_asked = holds_asked + 1;
      // hold the source until every pending word is out
      if (i == RANDOM_REQUESTS / 2) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (bus_words_due.size() != 0);
      end
      row       = '0;
      row.word  = random_request();
      row.typed = 1'b0;
      offer(row);
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk); while (bus_words_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && bus_words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
